[design/bdcs_pkg.sv]
// Package for the beeper duty cycle sampler: request codes, level constants,
// fraction format and divider request type. No dependencies.
package bdcs_pkg;
   localparam logic [2:0] REQ_LEVELS      = 3'd0;
   localparam logic [2:0] REQ_TACT_RESYNC = 3'd1;
   localparam logic [2:0] REQ_TACT_PLAIN  = 3'd2;
   localparam logic [2:0] REQ_SAMPLE      = 3'd3;
   localparam logic [2:0] REQ_FRAME       = 3'd4;
   localparam logic [9:0] MILLI_MIC  = 10'd330;
   localparam logic [9:0] MILLI_EAR  = 10'd660;
   localparam logic [9:0] MILLI_FULL = 10'd1000;
   // share fractions are Q0.FRACTION_BITS; one full share needs one more bit
   localparam int FRACTION_BITS = 16;
   localparam int QUOT_BITS     = FRACTION_BITS + 1;
   // tot*1000 < span*2^10, so ten quotient bits cover the per-mille result
   localparam int MILLI_STEPS   = 10;
   typedef struct packed {
      logic                 start;
      logic [4:0]           steps;
      logic [47:0]          rem0;
      logic [QUOT_BITS-1:0] low;
      logic [47:0]          den;
   } div_req_type;
endpackage

[design/beeper_duty_cycle_sampler_core.sv]
// Beeper duty cycle sampler, top level: request decoding, transition ring
// memory walk and result caching. Depends on bdcs_pkg and bdcs_divider.
//
// Tracks EAR/MIC output bits and a 32-bit tact counter. Level changes go into
// a ring of QUEUE_DEPTH entries (tact, ear, mic) in one synchronous RAM. A
// sample request walks the ring from the head, reading then integrating one
// entry at a time, up to the first entry at or after the window end, then
// runs four serial divisions (per-mille and Q0.16 for EAR and MIC) on one
// shared restoring divider. Level, tact, frame, cache-hit and empty-window
// transactions go through decode, raise rsp_valid, then wait to be
// collected. A computed sample walks the ring, closes the window and runs
// the divisions (two ten-bit per-mille and two 17-bit fraction quotients,
// each with load and collect), then takes the same response path. The ring
// needs no clearing: only entries inside the fill count are read.
// One transaction is in flight; the result sits in an output register and
// the next request is taken once it has been collected.
module beeper_duty_cycle_sampler_core #(
   parameter int QUEUE_DEPTH   = 8192
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic        req_ear_level,
   input  logic        req_mic_level,
   input  logic [31:0] req_tact_value,
   input  logic [47:0] req_sample_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [9:0]  rsp_left_milli,
   output logic [9:0]  rsp_right_milli,
   output logic [16:0] rsp_left_fraction,
   output logic [16:0] rsp_right_fraction,
   output logic        rsp_ear_now,
   output logic        rsp_mic_now,
   output logic [9:0]  rsp_level_milli
);
   import bdcs_pkg::*;

   localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_READ = 3'd1;
   localparam logic [2:0] ST_STEP = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_WAIT = 3'd4;
   localparam logic [2:0] ST_RESP = 3'd5;

   // ring memory: {tact, ear, mic}
   logic [33:0] ring_mem [QUEUE_DEPTH];
   logic [33:0] rd_data_ff;
   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;

   logic [2:0]  state_ff;
   logic        ear_ff, mic_ff;
   logic [31:0] tact_ff;
   logic [47:0] wstart_ff, end_ff, cursor_ff, cached_end_ff, span_ff;
   logic        wear_ff, wmic_ff, e_ff, m_ff;
   logic [AW-1:0] head_ff;
   logic [CW-1:0] count_ff, used_ff;
   logic        cvalid_ff;
   logic [9:0]  lm_ff, rm_ff;
   logic [16:0] lf_ff, rf_ff;
   logic [47:0] tot_e_ff, tot_m_ff;
   logic [1:0]  dsel_ff;
   div_req_type dreq;
   logic        dbusy;
   logic [QUOT_BITS-1:0] dq;

   bdcs_divider u_div (
      .clock(clock), .reset(reset), .req(dreq), .busy(dbusy), .quotient(dq)
   );

   logic [CW:0] tail_sum;
   assign tail_sum = {1'b0, CW'(head_ff)} + {1'b0, count_ff};
   assign wr_addr = (tail_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                    AW'(tail_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(tail_sum);
   logic [CW:0] rd_sum;
   assign rd_sum = {1'b0, CW'(head_ff)} + {1'b0, used_ff};
   assign rd_addr = (rd_sum >= (CW+1)'(QUEUE_DEPTH)) ?
                    AW'(rd_sum - (CW+1)'(QUEUE_DEPTH)) : AW'(rd_sum);

   logic accept;
   assign req_ready = state_ff == ST_IDLE;
   assign accept = req_valid && req_ready;
   logic lvl_change;
   assign lvl_change = (req_ear_level != ear_ff) || (req_mic_level != mic_ff);
   assign wr_en = accept && req_type == REQ_LEVELS && lvl_change &&
                  count_ff < CW'(QUEUE_DEPTH);

   always_ff @(posedge clock) begin
      if (wr_en) ring_mem[wr_addr] <= {tact_ff, req_ear_level, req_mic_level};
      rd_data_ff <= ring_mem[rd_addr];
   end

   // walk step on registered entry
   logic [47:0] ent_t, t_clamp, delta;
   assign ent_t   = {rd_data_ff[33:2], 16'd0};
   assign t_clamp = (ent_t < cursor_ff) ? cursor_ff : ent_t;
   assign delta   = t_clamp - cursor_ff;

   // divider operands over the window span; tot <= span keeps the start
   // remainder below the divisor: milli from tot*1000, fraction from tot<<FB
   logic [47:0] dtot;
   logic [57:0] milli_num;
   assign dtot = dsel_ff[0] ? tot_m_ff : tot_e_ff;
   assign milli_num = {10'd0, dtot} * 58'd1000;
   always_comb begin
      dreq.start = state_ff == ST_DIV;
      dreq.den   = span_ff;
      if (!dsel_ff[1]) begin
         dreq.steps = 5'(MILLI_STEPS);
         dreq.rem0  = milli_num[57:MILLI_STEPS];
         dreq.low   = {milli_num[MILLI_STEPS-1:0], {(QUOT_BITS-MILLI_STEPS){1'b0}}};
      end else begin
         dreq.steps = 5'(QUOT_BITS);
         dreq.rem0  = {1'b0, dtot[47:1]};
         dreq.low   = {dtot[0], {FRACTION_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid <= 1'b0;
         ear_ff <= 1'b0; mic_ff <= 1'b0; tact_ff <= '0;
         wstart_ff <= '0; wear_ff <= 1'b0; wmic_ff <= 1'b0;
         head_ff <= '0; count_ff <= '0; cached_end_ff <= '0; cvalid_ff <= 1'b0;
         lm_ff <= '0; rm_ff <= '0; lf_ff <= '0; rf_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_IDLE: if (accept) begin
               state_ff <= ST_RESP;
               unique case (req_type)
                  REQ_LEVELS: begin
                     if (lvl_change) begin
                        if (count_ff < CW'(QUEUE_DEPTH)) count_ff <= count_ff + 1'b1;
                        cvalid_ff <= 1'b0;
                     end
                     ear_ff <= req_ear_level;
                     mic_ff <= req_mic_level;
                  end
                  REQ_TACT_RESYNC: begin
                     if (req_tact_value < tact_ff) begin
                        wstart_ff <= {req_tact_value, 16'd0};
                        wear_ff <= ear_ff; wmic_ff <= mic_ff;
                        head_ff <= '0; count_ff <= '0; cvalid_ff <= 1'b0;
                     end
                     tact_ff <= req_tact_value;
                  end
                  REQ_TACT_PLAIN: tact_ff <= req_tact_value;
                  REQ_SAMPLE: begin
                     if (cvalid_ff && cached_end_ff == req_sample_end) begin
                        state_ff <= ST_RESP;
                     end else if (req_sample_end <= wstart_ff) begin
                        lm_ff <= ear_ff ? MILLI_FULL : '0;
                        rm_ff <= mic_ff ? MILLI_FULL : '0;
                        lf_ff <= ear_ff ? 17'(1 << FRACTION_BITS) : '0;
                        rf_ff <= mic_ff ? 17'(1 << FRACTION_BITS) : '0;
                        cached_end_ff <= req_sample_end; cvalid_ff <= 1'b1;
                     end else begin
                        end_ff <= req_sample_end;
                        span_ff <= req_sample_end - wstart_ff;
                        cursor_ff <= wstart_ff;
                        e_ff <= wear_ff; m_ff <= wmic_ff;
                        tot_e_ff <= '0; tot_m_ff <= '0;
                        used_ff <= '0;
                        state_ff <= ST_READ;
                     end
                  end
                  REQ_FRAME: cvalid_ff <= 1'b0;
                  default: ;
               endcase
            end
            ST_READ: begin
               if (used_ff < count_ff) state_ff <= ST_STEP;
               else begin
                  // close the window at end
                  if (e_ff) tot_e_ff <= tot_e_ff + (end_ff - cursor_ff);
                  if (m_ff) tot_m_ff <= tot_m_ff + (end_ff - cursor_ff);
                  head_ff <= rd_addr;
                  count_ff <= count_ff - used_ff;
                  wstart_ff <= end_ff;
                  wear_ff <= e_ff; wmic_ff <= m_ff;
                  dsel_ff <= 2'd0;
                  state_ff <= ST_DIV;
               end
            end
            ST_STEP: begin
               if (ent_t >= end_ff) begin
                  // entry lies at or past the end: it stays queued
                  if (e_ff) tot_e_ff <= tot_e_ff + (end_ff - cursor_ff);
                  if (m_ff) tot_m_ff <= tot_m_ff + (end_ff - cursor_ff);
                  head_ff <= rd_addr;
                  count_ff <= count_ff - used_ff;
                  wstart_ff <= end_ff;
                  wear_ff <= e_ff; wmic_ff <= m_ff;
                  dsel_ff <= 2'd0;
                  state_ff <= ST_DIV;
               end else begin
                  if (e_ff) tot_e_ff <= tot_e_ff + delta;
                  if (m_ff) tot_m_ff <= tot_m_ff + delta;
                  cursor_ff <= t_clamp;
                  e_ff <= rd_data_ff[1]; m_ff <= rd_data_ff[0];
                  used_ff <= used_ff + 1'b1;
                  state_ff <= ST_READ;
               end
            end
            ST_DIV: state_ff <= ST_WAIT;
            ST_WAIT: if (!dbusy) begin
               unique case (dsel_ff)
                  2'd0: lm_ff <= 10'(dq);
                  2'd1: rm_ff <= 10'(dq);
                  2'd2: lf_ff <= 17'(dq);
                  default: rf_ff <= 17'(dq);
               endcase
               if (dsel_ff == 2'd3) begin
                  cached_end_ff <= end_ff; cvalid_ff <= 1'b1;
                  state_ff <= ST_RESP;
               end else begin
                  dsel_ff <= dsel_ff + 1'b1;
                  state_ff <= ST_DIV;
               end
            end
            ST_RESP: begin
               if (!rsp_valid) rsp_valid <= 1'b1;
               else if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_left_milli     = lm_ff;
   assign rsp_right_milli    = rm_ff;
   assign rsp_left_fraction  = lf_ff;
   assign rsp_right_fraction = rf_ff;
   assign rsp_ear_now        = ear_ff;
   assign rsp_mic_now        = mic_ff;
   assign rsp_level_milli    = (ear_ff && mic_ff) ? MILLI_FULL :
                               ear_ff ? MILLI_EAR : mic_ff ? MILLI_MIC : 10'd0;
endmodule

[design/bdcs_divider.sv]
// Restoring divider, one quotient bit per cycle. Starts from a partial
// remainder below den and shifts in the low numerator bits. Depends on bdcs_pkg.
module bdcs_divider (
   input  logic                            clock,
   input  logic                            reset,
   input  bdcs_pkg::div_req_type           req,
   output logic                            busy,
   output logic [bdcs_pkg::QUOT_BITS-1:0]  quotient
);
   import bdcs_pkg::*;
   logic [47:0] rem_ff, den_ff, diff;
   logic [48:0] trial;
   logic        fits;
   logic [QUOT_BITS-1:0] low_ff, q_ff;
   logic [4:0]  cnt_ff;

   // remainder stays below den, so the difference fits in 48 bits
   assign trial = {rem_ff, low_ff[QUOT_BITS-1]};
   assign fits  = trial >= {1'b0, den_ff};
   assign diff  = trial[47:0] - den_ff;
   assign busy = cnt_ff != '0;
   assign quotient = q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (req.start) begin
         cnt_ff <= req.steps;
         rem_ff <= req.rem0;
         low_ff <= req.low;
         den_ff <= req.den;
         q_ff   <= '0;
      end else if (busy) begin
         cnt_ff <= cnt_ff - 1'b1;
         rem_ff <= fits ? diff : trial[47:0];
         low_ff <= {low_ff[QUOT_BITS-2:0], 1'b0};
         q_ff   <= {q_ff[QUOT_BITS-2:0], fits};
      end
   end
endmodule
